// ----- hdl/pcba_pkg.sv -----
// Shared types and constants for the page color bin allocator.
// Used by pcba_count_store and page_color_bin_allocator; no dependencies.
package pcba_pkg;

  // Width of every bin, cursor and start mark field on the ports.
  localparam int BIN_W = 9;

  // Register reset values and the start mark bump on cursor wrap.
  localparam logic [3:0]       COLOR_BITS_RST = 4'd9;
  localparam logic [3:0]       VAC_BITS_RST   = 4'd1;
  localparam logic [BIN_W-1:0] BIN_SKIP_RST   = 9'd20;
  localparam logic [BIN_W-1:0] LOOP_BUMP      = 9'd3;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_COLOR_BITS = 2'd0;
  localparam logic [1:0] REG_VAC_BITS   = 2'd1;
  localparam logic [1:0] REG_BIN_SKIP   = 2'd2;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_ALLOC  = 2'd2,
    MODE_NONE   = 2'd3
  } pcba_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } pcba_state_t;

  // Control for one access of the count store.
  typedef struct packed {
    logic rd;
    logic wr;
  } pcba_mem_ctl_t;

endpackage

// ----- hdl/page_color_bin_allocator.sv -----
// Page color bin allocator: per-bin page counts for the free and cache lists.
// Depends on pcba_pkg and pcba_count_store.
//
// Each transaction is handled alone by a small sequencer around one count
// memory with a single port and one increment/decrement unit. Add and remove
// pass through setup, one read, an evaluation and the done state; an invalid
// mode goes from setup straight to done; an allocation probes 1 to colors + 1
// bins, since every probe is a memory read followed by a compare and, on a
// hit, a write. The next transaction can be accepted in the cycle after its
// result is loaded.
// After reset the block clears both count lists, one entry a cycle, and
// accepts no item meanwhile; configuration writes are taken at any time. A
// finished result waits in an output register, so the next transaction may
// be accepted before the result is taken.
module page_color_bin_allocator import pcba_pkg::*; #(
  parameter int MAX_COLORS = 512,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [8:0] page_bin, [17:9] vcolor, [26:18] color_cursor,
  // [35:27] color_start, [36] match_color, [39:37] zero
  input  logic [39:0] in_tdata,
  // [1:0] mode, [2] list_select
  input  logic [2:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [8:0] bin, [17:9] next_cursor, [26:18] next_start, [31:27] zero
  output logic [31:0] out_tdata,
  // [0] ok
  output logic [0:0]  out_tuser,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CB_MAX = $clog2(MAX_COLORS + 1) - 1;
  localparam int IW     = CB_MAX;
  localparam int CBW    = $clog2(CB_MAX + 1);
  localparam int AW     = IW + 1;

  // Configuration registers.
  logic [3:0]       color_bits_r;
  logic [3:0]       vac_bits_r;
  logic [BIN_W-1:0] bin_skip_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_bits_r <= COLOR_BITS_RST;
      vac_bits_r   <= VAC_BITS_RST;
      bin_skip_r   <= BIN_SKIP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_COLOR_BITS: color_bits_r <= cfg_pwdata[3:0];
        REG_VAC_BITS:   vac_bits_r   <= cfg_pwdata[3:0];
        REG_BIN_SKIP:   bin_skip_r   <= cfg_pwdata[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_COLOR_BITS: cfg_prdata = 32'(color_bits_r);
      REG_VAC_BITS:   cfg_prdata = 32'(vac_bits_r);
      REG_BIN_SKIP:   cfg_prdata = 32'(bin_skip_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Effective color geometry.
  logic [CBW-1:0] cb;
  logic [CBW-1:0] vb;
  logic [IW-1:0]  pmask;
  logic [IW-1:0]  vmask;
  logic [IW-1:0]  vcols;
  logic [IW:0]    colors;

  assign cb     = (color_bits_r > 4'(CB_MAX)) ? CBW'(CB_MAX) : CBW'(color_bits_r);
  assign vb     = (CBW'(vac_bits_r) > cb || vac_bits_r > 4'(CB_MAX)) ? cb : CBW'(vac_bits_r);
  assign pmask  = ~({IW{1'b1}} << cb);
  assign vmask  = ~({IW{1'b1}} << vb);
  // When vb equals the index width this is zero, which is the same step
  // as a full turn around the bins.
  assign vcols  = IW'(1) << vb;
  assign colors = (IW + 1)'(1) << cb;

  // Sequencer registers.
  pcba_state_t      state_r, state_nxt;
  pcba_mode_t       mode_r;
  logic             list_r;
  logic [BIN_W-1:0] page_bin_r;
  logic [BIN_W-1:0] vcolor_r;
  logic [BIN_W-1:0] cursor_r;
  logic [BIN_W-1:0] start_r;
  logic             match_r;
  logic [IW-1:0]    probe_r, probe_nxt;
  logic [IW-1:0]    marker_r, marker_nxt;
  logic [IW:0]      iter_r, iter_nxt;
  logic             ok_r, ok_nxt;
  logic [IW-1:0]    res_bin_r, res_bin_nxt;
  logic [BIN_W-1:0] ncur_r, ncur_nxt;
  logic [BIN_W-1:0] nstart_r, nstart_nxt;

  // Output register.
  logic             out_valid_r;
  logic             out_ok_r;
  logic [BIN_W-1:0] out_bin_r;
  logic [BIN_W-1:0] out_ncur_r;
  logic [BIN_W-1:0] out_nstart_r;
  logic             out_load;

  // Count store.
  pcba_mem_ctl_t         mem_ctl;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  clear_busy;
  logic                  in_acc;

  pcba_count_store #(
    .AW (AW),
    .DW (COUNT_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .addr       ({list_r, probe_r}),
    .wdata      (mem_wdata),
    .rdata      (mem_rdata),
    .clear_busy (clear_busy)
  );

  assign in_tready = (state_r == ST_IDLE) && !clear_busy;
  assign in_acc    = in_tvalid && in_tready;

  // Allocation setup: align the cursor to the virtual color and advance it.
  logic [IW-1:0]    vc;
  logic [IW-1:0]    cur;
  logic [IW-1:0]    target;
  logic [IW-1:0]    nxt1;
  logic [BIN_W-1:0] bumped;
  logic             wrap;

  assign vc     = IW'(vcolor_r) & vmask;
  assign cur    = IW'(cursor_r);
  assign target = (cur + ((vc - cur) & vmask)) & pmask;
  assign nxt1   = (target + 1'b1) & pmask;
  assign wrap   = (nxt1 == (IW'(start_r) & pmask));
  assign bumped = start_r + LOOP_BUMP;

  // Probe stepping after an empty bin.
  logic [IW-1:0] skip_step;
  logic [IW-1:0] v_step;
  logic [IW-1:0] v_bump;
  logic          hit_marker;

  assign skip_step  = (probe_r + IW'(bin_skip_r)) & pmask;
  assign v_step     = (probe_r + vcols) & pmask;
  assign v_bump     = (v_step + 1'b1) & pmask;
  assign hit_marker = (v_step == marker_r);

  // The single increment/decrement unit on the count that was read.
  logic cnt_full;
  logic cnt_zero;

  assign cnt_full  = &mem_rdata;
  assign cnt_zero  = (mem_rdata == '0);
  assign mem_wdata = (mode_r == MODE_ADD) ? mem_rdata + 1'b1 : mem_rdata - 1'b1;

  always_comb begin
    state_nxt   = state_r;
    probe_nxt   = probe_r;
    marker_nxt  = marker_r;
    iter_nxt    = iter_r;
    ok_nxt      = ok_r;
    res_bin_nxt = res_bin_r;
    ncur_nxt    = ncur_r;
    nstart_nxt  = nstart_r;
    mem_ctl     = '0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        ok_nxt     = 1'b0;
        ncur_nxt   = cursor_r;
        nstart_nxt = start_r;
        iter_nxt   = '0;
        unique case (mode_r)
          MODE_ADD, MODE_REMOVE: begin
            probe_nxt   = IW'(page_bin_r) & pmask;
            res_bin_nxt = IW'(page_bin_r) & pmask;
            state_nxt   = ST_READ;
          end
          MODE_ALLOC: begin
            probe_nxt   = target;
            res_bin_nxt = target;
            if (wrap) begin
              nstart_nxt = bumped;
              ncur_nxt   = BIN_W'(IW'(bumped) & pmask);
            end else begin
              ncur_nxt = BIN_W'(nxt1);
            end
            state_nxt = ST_READ;
          end
          MODE_NONE: begin
            res_bin_nxt = '0;
            state_nxt   = ST_DONE;
          end
        endcase
      end
      ST_READ: begin
        mem_ctl.rd = 1'b1;
        state_nxt  = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (mode_r == MODE_ADD) begin
          if (!cnt_full) begin
            mem_ctl.wr = 1'b1;
            ok_nxt     = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (mode_r == MODE_REMOVE) begin
          if (!cnt_zero) begin
            mem_ctl.wr = 1'b1;
            ok_nxt     = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (!cnt_zero) begin
          mem_ctl.wr  = 1'b1;
          ok_nxt      = 1'b1;
          res_bin_nxt = probe_r;
          state_nxt   = ST_DONE;
        end else if (match_r || iter_r == colors) begin
          state_nxt = ST_DONE;
        end else begin
          // The first empty bin jumps by the skip and sets the marker; later
          // ones stride by the virtual colors and step past the marker.
          if (iter_r == '0) begin
            probe_nxt  = skip_step;
            marker_nxt = skip_step;
          end else if (hit_marker) begin
            probe_nxt  = v_bump;
            marker_nxt = v_bump;
          end else begin
            probe_nxt = v_step;
          end
          iter_nxt  = iter_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r   <= probe_nxt;
    marker_r  <= marker_nxt;
    iter_r    <= iter_nxt;
    ok_r      <= ok_nxt;
    res_bin_r <= res_bin_nxt;
    ncur_r    <= ncur_nxt;
    nstart_r  <= nstart_nxt;
    if (in_acc) begin
      mode_r     <= pcba_mode_t'(in_tuser[1:0]);
      list_r     <= in_tuser[2];
      page_bin_r <= in_tdata[8:0];
      vcolor_r   <= in_tdata[17:9];
      cursor_r   <= in_tdata[26:18];
      start_r    <= in_tdata[35:27];
      match_r    <= in_tdata[36];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r     <= ok_r;
      out_bin_r    <= BIN_W'(res_bin_r);
      out_ncur_r   <= ncur_r;
      out_nstart_r <= nstart_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {5'b0, out_nstart_r, out_ncur_r, out_bin_r};
  assign out_tuser[0] = out_ok_r;

`ifndef NO_ASSERTIONS
  // A count is evaluated only when the state before was the read state.
  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> $past(state_r) == ST_READ)
    else $error("evaluation without a preceding read");

  // The count store is written only while evaluating a probe.
  a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr |-> state_r == ST_EVAL && !clear_busy)
    else $error("count write outside evaluation");

  // The probe never runs past one full turn plus one bin.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> iter_r <= colors)
    else $error("probe count overran the number of colors");

  // An accepted transaction starts setup in the next cycle.
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_PREP)
    else $error("accepted transaction did not start");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_tready)
    else $error("pending result overwritten");
`endif

endmodule

// ----- hdl/pcba_count_store.sv -----
// Count memory for both lists with a clearing sweep after reset.
// Depends on pcba_pkg for the access control struct.
module pcba_count_store import pcba_pkg::*; #(
  parameter int AW = 10,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pcba_mem_ctl_t ctl,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata,
  output logic          clear_busy
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;
  logic [AW-1:0] clr_addr_r;
  logic          clear_busy_r;

  // The sweep zeroes one entry a cycle until the last address is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clear_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clear_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata      = rdata_r;
  assign clear_busy = clear_busy_r;

endmodule

// ----- bench/page_color_bin_allocator_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for page_color_bin_allocator: watches the item, result and register ports,
// keeps its own per-bin page counts for both lists and checks each result in order.
// Depends on pcba_pkg for the mode codes, register indexes and reset values.
module page_color_bin_allocator_checker import pcba_pkg::*; #(
  parameter int MAX_BINS = 512,
  parameter int COUNT_W  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          due_count
);

  localparam int LOG_BINS  = $clog2(MAX_BINS);
  localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

  typedef struct packed {
    logic             ok;
    logic [BIN_W-1:0] bin;
    logic [BIN_W-1:0] next_cursor;
    logic [BIN_W-1:0] next_start;
  } bin_outcome_t;

  logic [COUNT_W-1:0] free_pages  [MAX_BINS];
  logic [COUNT_W-1:0] cache_pages [MAX_BINS];
  logic [3:0]         color_bits_q;
  logic [3:0]         vac_bits_q;
  logic [BIN_W-1:0]   skip_q;
  bin_outcome_t       outcomes_due [$];
  bin_outcome_t       expected_res;
  bin_outcome_t       observed_res;
  int                 errors  = 0;
  int                 clr_idx;

  function automatic logic [COUNT_W-1:0] pages_in(input logic lst, input int unsigned idx);
    return lst ? cache_pages[idx] : free_pages[idx];
  endfunction

  function automatic void set_pages(input logic lst, input int unsigned idx,
                                    input logic [COUNT_W-1:0] val);
    if (lst) begin
      cache_pages[idx] = val;
    end else begin
      free_pages[idx] = val;
    end
  endfunction

  // Applies one transaction to the page counts and returns the result it must produce.
  function automatic bin_outcome_t serve_request(input logic [2:0] user, input logic [39:0] data);
    pcba_mode_t   mode;
    logic         lst;
    logic         match;
    int unsigned  page_bin, vcolor, cursor, start;
    int unsigned  cb, vb, colors, pmask, vcols, vmask;
    int unsigned  cnt, target, nxt, probe, marker, i;
    bin_outcome_t res;
    mode     = pcba_mode_t'(user[1:0]);
    lst      = user[2];
    page_bin = 32'(data[8:0]);
    vcolor   = 32'(data[17:9]);
    cursor   = 32'(data[26:18]);
    start    = 32'(data[35:27]);
    match    = data[36];
    // Oversized register values saturate: colors to the store size, virtual colors to colors.
    cb     = (32'(color_bits_q) < LOG_BINS) ? 32'(color_bits_q) : LOG_BINS;
    vb     = (32'(vac_bits_q) < cb) ? 32'(vac_bits_q) : cb;
    colors = 1 << cb;
    pmask  = colors - 1;
    vcols  = 1 << vb;
    vmask  = vcols - 1;
    res.ok          = 1'b0;
    res.bin         = '0;
    res.next_cursor = BIN_W'(cursor);
    res.next_start  = BIN_W'(start);
    unique case (mode)
      MODE_ADD: begin
        target  = page_bin & pmask;
        res.bin = BIN_W'(target);
        if (pages_in(lst, target) != COUNT_FULL) begin
          set_pages(lst, target, pages_in(lst, target) + 1'b1);
          res.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        target  = page_bin & pmask;
        res.bin = BIN_W'(target);
        if (pages_in(lst, target) != '0) begin
          set_pages(lst, target, pages_in(lst, target) - 1'b1);
          res.ok = 1'b1;
        end
      end
      MODE_ALLOC: begin
        // Raise the cursor by the least amount that lands on the wanted virtual color.
        cnt    = cursor + (((vcolor & vmask) - cursor) & vmask);
        target = cnt & pmask;
        nxt    = (target + 1) & pmask;
        if (nxt == (start & pmask)) begin
          res.next_start = BIN_W'(start + 32'(LOOP_BUMP));
          nxt            = 32'(res.next_start) & pmask;
        end
        res.next_cursor = BIN_W'(nxt);
        res.bin         = BIN_W'(target);
        probe           = target;
        marker          = 0;
        for (i = 0; i <= colors; i++) begin
          if (pages_in(lst, probe) != '0) begin
            set_pages(lst, probe, pages_in(lst, probe) - 1'b1);
            res.ok  = 1'b1;
            res.bin = BIN_W'(probe);
            break;
          end
          if (match) begin
            break;
          end
          if (i == 0) begin
            probe  = (probe + 32'(skip_q)) & pmask;
            marker = probe;
          end else begin
            probe = (probe + vcols) & pmask;
            // Landing on the marker means a full lap of this stride; shift by one bin.
            if (probe == marker) begin
              probe  = (probe + 1) & pmask;
              marker = probe;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (clr_idx = 0; clr_idx < MAX_BINS; clr_idx++) begin
        free_pages[clr_idx]  = '0;
        cache_pages[clr_idx] = '0;
      end
      outcomes_due.delete();
      color_bits_q = COLOR_BITS_RST;
      vac_bits_q   = VAC_BITS_RST;
      skip_q       = BIN_SKIP_RST;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        unique case (cfg_paddr[3:2])
          REG_COLOR_BITS: color_bits_q = cfg_pwdata[3:0];
          REG_VAC_BITS:   vac_bits_q   = cfg_pwdata[3:0];
          REG_BIN_SKIP:   skip_q       = cfg_pwdata[BIN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        outcomes_due.push_back(serve_request(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        observed_res.ok          = out_tuser[0];
        observed_res.bin         = out_tdata[8:0];
        observed_res.next_cursor = out_tdata[17:9];
        observed_res.next_start  = out_tdata[26:18];
        if (outcomes_due.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction outstanding, expected none, actual %h",
                   $time, observed_res);
        end else begin
          expected_res = outcomes_due.pop_front();
          check_field("ok", int'(expected_res.ok), int'(observed_res.ok));
          check_field("bin", int'(expected_res.bin), int'(observed_res.bin));
          check_field("next_cursor", int'(expected_res.next_cursor),
                      int'(observed_res.next_cursor));
          check_field("next_start", int'(expected_res.next_start),
                      int'(observed_res.next_start));
        end
      end
    end
    fail_count <= errors;
    due_count  <= outcomes_due.size();
  end

endmodule

// ----- bench/page_color_bin_allocator_test.sv -----
`timescale 1ns / 100ps
// Top of the page_color_bin_allocator bench: clock, reset, register writes and item stimulus.
// Depends on pcba_pkg, the allocator RTL and page_color_bin_allocator_checker.
module page_color_bin_allocator_test;
  import pcba_pkg::*;

  localparam int NUM_PHASES       = 7;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int IDLE_PCT         = 11;
  localparam int LONG_HOLD        = 300;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;
  logic [2:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          due_count;
  bit          steady      = 1'b0;
  bit          hold_ask    = 1'b0;

  // Register settings per phase; the first matches the reset values, several others hit the extremes.
  int phase_color_bits [NUM_PHASES] = '{9, 15, 0, 2, 4, 9, 6};
  int phase_vac_bits   [NUM_PHASES] = '{1, 15, 0, 1, 9, 9, 3};
  int phase_skip       [NUM_PHASES] = '{20, 511, 0, 1, 3, 0, 100};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  page_color_bin_allocator i_dut (.*);

  page_color_bin_allocator_checker i_checker (.*);

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic offer_item(input pcba_mode_t md, input logic lst, input logic [8:0] pb,
                            input logic [8:0] vc, input logic [8:0] cur, input logic [8:0] st,
                            input logic mc);
    int gap;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      gap = int'($urandom_range(4, 1));
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, mc, st, cur, vc, pb};
    in_tuser  <= {lst, md};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (extra) @(posedge clk);
  endtask

  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_left = LONG_HOLD;
        hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    pcba_mode_t md;
    logic [8:0] cur;
    logic [8:0] st;
    int         pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle(12);
      end
      write_reg(REG_COLOR_BITS, phase_color_bits[p]);
      write_reg(REG_VAC_BITS, phase_vac_bits[p]);
      write_reg(REG_BIN_SKIP, phase_skip[p]);
      if (p == 0) begin
        // Allocation from an empty list walks every bin and fails.
        offer_item(MODE_ALLOC, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_ADD, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_ADD, 1'b0, 9'd511, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_ADD, 1'b1, 9'd511, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_REMOVE, 1'b0, 9'd5, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_REMOVE, 1'b0, 9'd511, 9'd0, 9'd0, 9'd0, 1'b0);
        // Cursor wraps onto the start mark; exact color wanted but the bin is empty.
        offer_item(MODE_ALLOC, 1'b0, 9'd0, 9'd1, 9'd510, 9'd0, 1'b1);
        offer_item(MODE_ADD, 1'b0, 9'd20, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_ALLOC, 1'b0, 9'd0, 9'd0, 9'd0, 9'd100, 1'b0);
        // Target now empty, so the skip step finds the page.
        offer_item(MODE_ALLOC, 1'b0, 9'd0, 9'd0, 9'd0, 9'd100, 1'b0);
        // An odd bin is only reached after the stride laps back onto the marker.
        offer_item(MODE_ADD, 1'b0, 9'd41, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_ALLOC, 1'b0, 9'd0, 9'd0, 9'd0, 9'd100, 1'b0);
        offer_item(MODE_ALLOC, 1'b1, 9'd511, 9'd511, 9'd511, 9'd511, 1'b1);
        offer_item(MODE_ALLOC, 1'b1, 9'd0, 9'd1, 9'd509, 9'd510, 1'b0);
        // The bumped start mark wraps past the top of its range.
        offer_item(MODE_ALLOC, 1'b0, 9'd0, 9'd0, 9'd508, 9'd509, 1'b0);
        offer_item(MODE_NONE, 1'b1, 9'd511, 9'd511, 9'd511, 9'd511, 1'b1);
        offer_item(MODE_NONE, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0, 1'b0);
        offer_item(MODE_ADD, 1'b1, 9'd511, 9'd511, 9'd511, 9'd511, 1'b1);
        offer_item(MODE_REMOVE, 1'b1, 9'd0, 9'd0, 9'd0, 9'd0, 1'b0);
      end
      steady = (p == 4);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (p == 2 && k == 30) begin
          hold_ask = 1'b1;
        end
        pick = int'($urandom_range(99));
        if (pick < 40) begin
          md = MODE_ADD;
        end else if (pick < 55) begin
          md = MODE_REMOVE;
        end else if (pick < 95) begin
          md = MODE_ALLOC;
        end else begin
          md = MODE_NONE;
        end
        cur = 9'($urandom_range(511));
        // Half the start marks sit just past the cursor so the wrap case comes up often.
        if ($urandom_range(1) == 1) begin
          st = cur + 9'($urandom_range(3));
        end else begin
          st = 9'($urandom_range(511));
        end
        offer_item(md, 1'($urandom_range(1)), 9'($urandom_range(511)),
                   9'($urandom_range(511)), cur, st, $urandom_range(3) == 0);
      end
    end
    steady = 1'b0;
    settle(1100);
    if (fail_count == 0 && due_count == 0) begin
      $display("page_color_bin_allocator: match");
    end else begin
      $display("page_color_bin_allocator: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("page_color_bin_allocator: mismatch");
    $finish;
  end

endmodule
